// ----- design/glcmacc_pkg.sv -----
package glcmacc_pkg;

  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned DIR_W       = 2;
  localparam int unsigned COUNT_OUT_W = 32;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned NUM_DIRS    = 4;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // table numbers, also the slot of each neighbor in a job
  localparam int unsigned DIR_0   = 0;  // left
  localparam int unsigned DIR_45  = 1;  // upper right
  localparam int unsigned DIR_90  = 2;  // upper
  localparam int unsigned DIR_135 = 3;  // upper left

  localparam int unsigned JOB_QUEUE_DEPTH    = 4;
  localparam int unsigned RESULT_QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_READ  = 1'b1
  } item_kind_e;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_INC1     = 3'd1,
    OP_INC2     = 3'd2,
    OP_READ     = 3'd3,
    OP_READ_CLR = 3'd4,
    OP_ZERO     = 3'd5
  } bank_op_e;

  // one classified item on its way from front to back
  typedef struct packed {
    item_kind_e                         kind;
    logic [PIXEL_W-1:0]                 level;     // pixel level or first_level
    logic [PIXEL_W-1:0]                 other;     // second_level
    logic [DIR_W-1:0]                   dir;
    logic                               clr;
    logic                               in_range;
    logic [NUM_DIRS-1:0]                nb_valid;
    logic [NUM_DIRS-1:0][PIXEL_W-1:0]   nb;
  } job_t;

endpackage

// ----- design/glcmacc_if.sv -----
interface glcmacc_item_if;
  import glcmacc_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [PIXEL_W-1:0] pixel;
  logic [DIR_W-1:0]   direction;
  logic [PIXEL_W-1:0] first_level;
  logic [PIXEL_W-1:0] second_level;
  logic               clear_after_read;

  modport source (
    output valid, kind, pixel, direction, first_level, second_level, clear_after_read,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel, direction, first_level, second_level, clear_after_read,
    output ready
  );
endinterface

interface glcmacc_result_if;
  import glcmacc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COUNT_OUT_W-1:0] count;

  modport source (output valid, count, input ready);
  modport sink (input valid, count, output ready);
endinterface

interface glcmacc_cfg_if;
  import glcmacc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/glcmacc_fifo.sv -----
module glcmacc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ----- design/glcmacc_front.sv -----
module glcmacc_front #(
  parameter int unsigned GRAY_LEVELS    = 256,
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  glcmacc_item_if.sink        item_i,
  glcmacc_cfg_if.sink         cfg_i,
  input  logic                clearing_i,
  input  logic                job_full_i,
  output logic                job_push_o,
  output glcmacc_pkg::job_t   job_o
);

  import glcmacc_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned WB    = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned CW    = (WB > CFG_DATA_W) ? WB : CFG_DATA_W;
  localparam int unsigned HW    = CFG_DATA_W;

  localparam logic [PIXEL_W:0]   LEVELS_EXT = (PIXEL_W + 1)'(GRAY_LEVELS);
  localparam logic [PIXEL_W-1:0] LEVEL_TOP  = PIXEL_W'(GRAY_LEVELS - 1);

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_UPPER = 3'b010,
    F_PUSH  = 3'b100
  } front_state_e;

  function automatic logic [PIXEL_W-1:0] level_of(input logic [PIXEL_W-1:0] v);
    if ({1'b0, v} >= LEVELS_EXT) return LEVEL_TOP;
    return v;
  endfunction

  front_state_e       state_q, state_d;
  logic [HW-1:0]      width_q, height_q;
  logic [COL_W-1:0]   col_q, col_d, col_s, pcol_q;
  logic [ROW_W-1:0]   row_q, row_d, row_s;
  logic [PIXEL_W-1:0] left_q, ul_q, line_rd_q;
  logic [PIXEL_W-1:0] line_mem [MAX_LINE_WIDTH];
  job_t               job_q, job_d;

  logic [CW-1:0]      w_ext, w_eff, col_n1;
  logic [HW-1:0]      h_eff, row_a, row_b;
  logic               wrap_in, wrap_out, has_left, has_up, has_ur;
  logic               in_ready, accept, accept_pix;
  logic               mem_re, mem_we;
  logic [COL_W-1:0]   mem_raddr;

  // effective sizes and the position of the incoming pixel
  always_comb begin
    w_ext = CW'(width_q);
    if (w_ext == '0) w_eff = CW'(1);
    else if (w_ext > CW'(MAX_LINE_WIDTH)) w_eff = CW'(MAX_LINE_WIDTH);
    else w_eff = w_ext;

    if (height_q == '0) h_eff = HW'(1);
    else if (height_q > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = height_q;

    wrap_in = (CW'(col_q) >= w_eff);
    col_s   = wrap_in ? '0 : col_q;
    row_a   = wrap_in ? (HW'(row_q) + HW'(1)) : HW'(row_q);
    row_s   = (row_a >= h_eff) ? '0 : row_a[ROW_W-1:0];

    col_n1   = CW'(col_s) + CW'(1);
    wrap_out = (col_n1 >= w_eff);
    row_b    = HW'(row_s) + HW'(1);
    if (wrap_out) begin
      col_d = '0;
      row_d = (row_b >= h_eff) ? '0 : row_b[ROW_W-1:0];
    end else begin
      col_d = col_n1[COL_W-1:0];
      row_d = row_s;
    end

    has_left = (col_s != '0);
    has_up   = (row_s != '0);
    has_ur   = has_up && !wrap_out;
  end

  assign in_ready     = !clearing_i &&
                        ((state_q == F_IDLE) || ((state_q == F_PUSH) && !job_full_i));
  assign item_i.ready = in_ready;
  assign accept       = item_i.valid && in_ready;
  assign accept_pix   = accept && (item_i.kind == KIND_PIXEL);
  assign job_push_o   = (state_q == F_PUSH) && !job_full_i;
  assign cfg_i.ready  = 1'b1;

  // classify the item into a job
  always_comb begin
    job_d          = '0;
    job_d.kind     = item_kind_e'(item_i.kind);
    if (item_i.kind == KIND_PIXEL) begin
      job_d.level             = level_of(item_i.pixel);
      job_d.nb[DIR_0]         = left_q;
      job_d.nb[DIR_135]       = ul_q;
      job_d.nb_valid[DIR_0]   = has_left;
      job_d.nb_valid[DIR_45]  = has_ur;
      job_d.nb_valid[DIR_90]  = has_up;
      job_d.nb_valid[DIR_135] = has_left && has_up;
    end else begin
      job_d.level    = item_i.first_level;
      job_d.other    = item_i.second_level;
      job_d.dir      = item_i.direction;
      job_d.clr      = item_i.clear_after_read;
      job_d.in_range = ({1'b0, item_i.first_level} < LEVELS_EXT) &&
                       ({1'b0, item_i.second_level} < LEVELS_EXT);
    end
  end

  // the upper-right level arrives from the line buffer in the push cycle
  always_comb begin
    job_o = job_q;
    if (job_q.kind == KIND_PIXEL) job_o.nb[DIR_45] = level_of(line_rd_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = accept_pix ? F_UPPER : F_PUSH;
      end
      F_UPPER: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!job_full_i) begin
          if (accept) state_d = accept_pix ? F_UPPER : F_PUSH;
          else state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // read the upper level at accept, the upper-right one in the next cycle
  assign mem_re    = accept_pix || (state_q == F_UPPER);
  assign mem_we    = (state_q == F_UPPER);
  assign mem_raddr = (state_q == F_UPPER) ? (pcol_q + COL_W'(1)) : col_s;

  always_ff @(posedge clk_i) begin
    if (mem_re) line_rd_q <= line_mem[mem_raddr];
    if (mem_we) line_mem[pcol_q] <= job_q.level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      ul_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
          CFG_IMAGE_HEIGHT: height_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (accept_pix) begin
        col_q  <= col_d;
        row_q  <= row_d;
        left_q <= level_of(item_i.pixel);
      end
      if (state_q == F_UPPER) ul_q <= level_of(line_rd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q  <= job_d;
      pcol_q <= col_s;
    end else if (state_q == F_UPPER) begin
      job_q.nb[DIR_90] <= level_of(line_rd_q);
    end
  end

endmodule

// ----- design/glcmacc_bank.sv -----
module glcmacc_bank #(
  parameter int unsigned ADDR_W     = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  glcmacc_pkg::bank_op_e     op_i,
  input  logic [ADDR_W-1:0]         addr_i,
  output logic [COUNT_BITS-1:0]     rdata_o
);

  import glcmacc_pkg::*;

  logic [COUNT_BITS-1:0] mem [2**ADDR_W];
  logic [COUNT_BITS-1:0] rdata_q, fwd_data_q, old, wdata;
  logic [COUNT_BITS:0]   sum;
  logic [ADDR_W-1:0]     s1_addr_q;
  bank_op_e              s1_op_q;
  logic                  fwd_q, fwd_d, re, we;

  // the write of the previous op lands with this read; take its value instead
  assign old     = fwd_q ? fwd_data_q : rdata_q;
  assign rdata_o = old;
  assign sum     = {1'b0, old} + ((s1_op_q == OP_INC2) ? (COUNT_BITS + 1)'(2)
                                                       : (COUNT_BITS + 1)'(1));
  assign re      = op_i inside {OP_INC1, OP_INC2, OP_READ, OP_READ_CLR};

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    case (s1_op_q)
      OP_INC1, OP_INC2: begin
        we    = 1'b1;
        wdata = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      end
      OP_READ_CLR, OP_ZERO: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  assign fwd_d = we && (op_i != OP_NONE) && (addr_i == s1_addr_q);

  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem[addr_i];
    if (we) mem[s1_addr_q] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_op_q <= OP_NONE;
      fwd_q   <= 1'b0;
    end else begin
      s1_op_q <= op_i;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= addr_i;
    fwd_data_q <= wdata;
  end

endmodule

// ----- design/glcmacc_back.sv -----
module glcmacc_back #(
  parameter int unsigned GRAY_LEVELS = 256,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  glcmacc_pkg::job_t                     job_i,
  input  logic                                  job_empty_i,
  output logic                                  job_pop_o,
  input  logic                                  res_full_i,
  input  logic                                  res_empty_i,
  output logic                                  res_push_o,
  output logic [glcmacc_pkg::COUNT_OUT_W-1:0]   res_count_o,
  output logic                                  clearing_o
);

  import glcmacc_pkg::*;

  localparam int unsigned LB = $clog2(GRAY_LEVELS);
  localparam int unsigned AW = 2 * LB;

  bank_op_e                      op [NUM_DIRS];
  logic [NUM_DIRS-1:0][AW-1:0]   addr;
  logic [COUNT_BITS-1:0]         bank_rdata [NUM_DIRS];
  logic [COUNT_BITS-1:0]         sel;
  logic [COUNT_OUT_W-1:0]        sat_count;

  logic              clr_q;
  logic [AW-1:0]     clr_addr_q;
  logic              phase_q, phase_d;
  logic              rd_pend_q, rd_pend_d;
  logic              rd_zero_q, rd_zero_d;
  logic [DIR_W-1:0]  rd_dir_q, rd_dir_d;
  logic              read_room;

  // room for a result once the pending one is in the queue
  assign read_room  = res_empty_i || (!rd_pend_q && !res_full_i);
  assign clearing_o = clr_q;

  always_comb begin
    logic [LB-1:0] p;
    logic [LB-1:0] n;
    p         = job_i.level[LB-1:0];
    n         = '0;
    job_pop_o = 1'b0;
    phase_d   = phase_q;
    rd_pend_d = 1'b0;
    rd_zero_d = rd_zero_q;
    rd_dir_d  = rd_dir_q;
    for (int j = 0; j < NUM_DIRS; j++) begin
      op[j]   = OP_NONE;
      addr[j] = '0;
    end

    if (clr_q) begin
      for (int j = 0; j < NUM_DIRS; j++) begin
        op[j]   = OP_ZERO;
        addr[j] = clr_addr_q;
      end
    end else if (!job_empty_i) begin
      if (job_i.kind == KIND_PIXEL) begin
        // first slot: [p][n], doubled when both are equal; second slot: [n][p]
        for (int j = 0; j < NUM_DIRS; j++) begin
          n = job_i.nb[j][LB-1:0];
          if (!phase_q) begin
            addr[j] = {p, n};
            if (job_i.nb_valid[j]) op[j] = (p == n) ? OP_INC2 : OP_INC1;
          end else begin
            addr[j] = {n, p};
            if (job_i.nb_valid[j] && (p != n)) op[j] = OP_INC1;
          end
        end
        phase_d   = !phase_q;
        job_pop_o = phase_q;
      end else if (read_room) begin
        job_pop_o = 1'b1;
        rd_pend_d = 1'b1;
        rd_zero_d = !job_i.in_range;
        rd_dir_d  = job_i.dir;
        for (int j = 0; j < NUM_DIRS; j++) begin
          if (job_i.in_range && (DIR_W'(j) == job_i.dir)) begin
            op[j]   = job_i.clr ? OP_READ_CLR : OP_READ;
            addr[j] = {job_i.level[LB-1:0], job_i.other[LB-1:0]};
          end
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_DIRS; g++) begin : g_bank
    glcmacc_bank #(
      .ADDR_W     (AW),
      .COUNT_BITS (COUNT_BITS)
    ) u_bank (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op[g]),
      .addr_i  (addr[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  assign sel = bank_rdata[rd_dir_q];

  if (COUNT_BITS > COUNT_OUT_W) begin : g_sat
    assign sat_count = (|sel[COUNT_BITS-1:COUNT_OUT_W]) ? '1 : sel[COUNT_OUT_W-1:0];
  end else begin : g_ext
    assign sat_count = COUNT_OUT_W'(sel);
  end

  assign res_push_o  = rd_pend_q;
  assign res_count_o = rd_zero_q ? '0 : sat_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      phase_q    <= 1'b0;
      rd_pend_q  <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == '1) clr_q <= 1'b0;
      end
      phase_q   <= phase_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_zero_q <= rd_zero_d;
    rd_dir_q  <= rd_dir_d;
  end

endmodule

// ----- design/glcm_accumulate_four_directions.sv -----
// Pixels: each pixel takes two read-modify-write slots in every direction bank, one for
//   the [p][n] update and one for the [n][p] update, and the line buffer has a single
//   read port; read items are held by the room check on the count queue.
// Reset: asynchronous, active low; a clearing pass then zeroes all four tables before
//   the first item is taken.
module glcm_accumulate_four_directions #(
  parameter int unsigned GRAY_LEVELS    = 256,
  parameter int unsigned MAX_LINE_WIDTH = 4096,
  parameter int unsigned COUNT_BITS     = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  glcmacc_item_if.sink      item_i,
  glcmacc_cfg_if.sink       cfg_i,
  glcmacc_result_if.source  result_o
);

  import glcmacc_pkg::*;

  localparam int unsigned JOB_W = $bits(job_t);

  // Front: hold position, the left and upper-left levels, and the previous row;
  // classify each beat into a job with all in-image neighbors resolved.
  // Back: expand a job into per-bank increments or one read, two slots per pixel.
  // The job queue between them lets the front take the next beat while the
  // back still works on earlier pixels.

  job_t                    job_wr, job_rd;
  logic [JOB_W-1:0]        job_rd_bits;
  logic                    job_push, job_pop, job_full, job_empty;
  logic                    clearing;

  logic                    res_push, res_full, res_empty;
  logic [COUNT_OUT_W-1:0]  res_count, res_data;

  glcmacc_front #(
    .GRAY_LEVELS    (GRAY_LEVELS),
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_i      (cfg_i),
    .clearing_i (clearing),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_wr)
  );

  glcmacc_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_wr),
    .pop_i   (job_pop),
    .data_o  (job_rd_bits),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  assign job_rd = job_t'(job_rd_bits);

  glcmacc_back #(
    .GRAY_LEVELS (GRAY_LEVELS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_rd),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_empty_i (res_empty),
    .res_push_o  (res_push),
    .res_count_o (res_count),
    .clearing_o  (clearing)
  );

  // Results wait here; a stalled sink holds the back once a read item at the head of the job queue finds no room.
  glcmacc_fifo #(
    .WIDTH (COUNT_OUT_W),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_count),
    .pop_i   (result_o.ready),
    .data_o  (res_data),
    .full_o  (res_full),
    .empty_o (res_empty)
  );

  assign result_o.valid = !res_empty;
  assign result_o.count = res_data;

endmodule
